FILE: sv/stxdef_pkg.sv
// ---------------------------------------------------------------------------
// stxdef_pkg
// Shared types and constants for the STX/ETX escape deframer with its ring.
// ---------------------------------------------------------------------------
`default_nettype none

package stxdef_pkg;

  // default ring size
  localparam int RING_DEPTH_DEF = 64;

  // control characters on the serial line
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ESC = 8'h1B;

  // reported frame state codes
  localparam logic [1:0] FS_AWAIT = 2'd0;
  localparam logic [1:0] FS_FRAME = 2'd1;
  localparam logic [1:0] FS_ESC   = 2'd2;
  localparam logic [1:0] FS_DONE  = 2'd3;

  // item kinds
  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SKIP = 2'd3
  } op_t;

  // class of a received byte
  typedef enum logic [1:0] {
    BC_OTHER = 2'd0,
    BC_STX   = 2'd1,
    BC_ETX   = 2'd2,
    BC_ESC   = 2'd3
  } bclass_t;

  // parser state, one-hot
  typedef enum logic [3:0] {
    PS_AWAIT = 4'b0001,
    PS_FRAME = 4'b0010,
    PS_ESC   = 4'b0100,
    PS_DONE  = 4'b1000
  } pstate_t;

  // input transfer
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [7:0] offset;
  } in_t;

  // result transfer
  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       byte_stored;
    logic       is_empty;
    logic       is_full;
    logic [1:0] frame_state;
  } out_t;

  // classified item held in the queue
  typedef struct packed {
    op_t        op;
    bclass_t    bclass;
    logic [7:0] rx_byte;
    logic [7:0] offset;
    logic [7:0] off_quot;
  } item_t;

endpackage

`default_nettype wire

FILE: sv/stxdef_front.sv
// ---------------------------------------------------------------------------
// stxdef_front
// Classifies an incoming transfer: decodes its kind, the class of the
// received byte, and the quotient of the offset by the ring depth.
// ---------------------------------------------------------------------------
`default_nettype none

module stxdef_front
  import stxdef_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  in_t   in_data,
  output item_t item
);

  // reciprocal of the depth, scaled by 2^16, rounded down
  localparam int RECIP = 65536 / RING_DEPTH;
  localparam logic [23:0] RECIP_W = 24'(RECIP);

  logic [23:0] prod;

  // offset quotient estimate, at most one below the true value
  assign prod = {16'b0, in_data.offset} * RECIP_W;

  // byte classification and field pass-through
  always_comb begin
    item          = '0;
    item.op       = op_t'(in_data.kind);
    item.rx_byte  = in_data.rx_byte;
    item.offset   = in_data.offset;
    item.off_quot = prod[23:16];
    if (in_data.rx_byte == CH_STX) begin
      item.bclass = BC_STX;
    end else if (in_data.rx_byte == CH_ETX) begin
      item.bclass = BC_ETX;
    end else if (in_data.rx_byte == CH_ESC) begin
      item.bclass = BC_ESC;
    end else begin
      item.bclass = BC_OTHER;
    end
  end

endmodule

`default_nettype wire

FILE: sv/stxdef_queue.sv
// ---------------------------------------------------------------------------
// stxdef_queue
// Two-entry queue between the classifier and the execution side.
// ---------------------------------------------------------------------------
`default_nettype none

module stxdef_queue
  import stxdef_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t      entry_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/stxdef_back.sv
// ---------------------------------------------------------------------------
// stxdef_back
// Executes classified items: runs the frame parser, owns the ring memory
// and its pointers, and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module stxdef_back
  import stxdef_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] ONE  = PTR_W'(1);
  localparam logic [9:0] DEPTH_W = 10'(RING_DEPTH);

  logic [7:0] ring_mem [RING_DEPTH];

  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic             full_r, full_nxt;
  pstate_t          ps_r, ps_nxt;

  logic             out_valid_r;
  out_t             out_meta_r, meta_nxt;
  logic [7:0]       rd_data_r;
  logic             rd_sel_r;

  logic             fire, empty, store, rd_en;
  logic [PTR_W-1:0] wp_inc, rp_inc, off_ptr, rd_addr;
  logic [9:0]       qd, rem0, rem1, sum;

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;
  assign empty = !full_r && (wp_r == rp_r);

  assign wp_inc = (wp_r == LAST) ? '0 : wp_r + ONE;
  assign rp_inc = (rp_r == LAST) ? '0 : rp_r + ONE;

  // offset modulo depth, then read pointer plus offset modulo depth
  assign qd   = {2'b0, q_item.off_quot} * DEPTH_W;
  assign rem0 = {2'b0, q_item.offset} - qd;
  assign rem1 = (rem0 >= DEPTH_W) ? rem0 - DEPTH_W : rem0;
  assign sum  = {{(10 - PTR_W){1'b0}}, rp_r} + rem1;
  always_comb begin
    if (sum >= DEPTH_W) begin
      off_ptr = PTR_W'(sum - DEPTH_W);
    end else begin
      off_ptr = sum[PTR_W-1:0];
    end
  end

  // parser and ring pointer update
  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    full_nxt = full_r;
    ps_nxt   = ps_r;
    store    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = rp_r;
    case (q_item.op)
      OP_RX: begin
        case (ps_r)
          PS_AWAIT: begin
            case (q_item.bclass)
              BC_STX:  ps_nxt = PS_FRAME;
              BC_ETX:  ps_nxt = PS_DONE;
              BC_ESC:  ps_nxt = PS_ESC;
              default: ps_nxt = PS_AWAIT;
            endcase
          end
          PS_FRAME: begin
            case (q_item.bclass)
              BC_ETX:  ps_nxt = PS_DONE;
              BC_ESC:  ps_nxt = PS_ESC;
              default: store  = 1'b1;
            endcase
          end
          PS_ESC: begin
            store  = 1'b1;
            ps_nxt = PS_FRAME;
          end
          default: ps_nxt = ps_r;
        endcase
        if (store) begin
          wp_nxt   = wp_inc;
          rp_nxt   = full_r ? rp_inc : rp_r;
          full_nxt = (wp_inc == (full_r ? rp_inc : rp_r));
        end
      end
      OP_POP: begin
        if (!empty) begin
          rd_en    = 1'b1;
          rp_nxt   = rp_inc;
          full_nxt = 1'b0;
        end
      end
      OP_PEEK: begin
        rd_en   = 1'b1;
        rd_addr = off_ptr;
      end
      default: begin
        rp_nxt   = off_ptr;
        full_nxt = 1'b0;
        ps_nxt   = PS_AWAIT;
      end
    endcase
  end

  // result fields other than the read byte
  always_comb begin
    meta_nxt             = '0;
    meta_nxt.read_valid  = rd_en;
    meta_nxt.byte_stored = store;
    meta_nxt.is_full     = full_nxt;
    meta_nxt.is_empty    = !full_nxt && (wp_nxt == rp_nxt);
    case (ps_nxt)
      PS_AWAIT: meta_nxt.frame_state = FS_AWAIT;
      PS_FRAME: meta_nxt.frame_state = FS_FRAME;
      PS_ESC:   meta_nxt.frame_state = FS_ESC;
      PS_DONE:  meta_nxt.frame_state = FS_DONE;
      default:  meta_nxt.frame_state = FS_AWAIT;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      full_r      <= 1'b0;
      ps_r        <= PS_AWAIT;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        wp_r   <= wp_nxt;
        rp_r   <= rp_nxt;
        full_r <= full_nxt;
        ps_r   <= ps_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_meta_r <= meta_nxt;
      rd_sel_r   <= rd_en;
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (fire && store) begin
      ring_mem[wp_r] <= q_item.rx_byte;
    end
    if (fire && rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data           = out_meta_r;
    out_data.read_data = rd_sel_r ? rd_data_r : 8'h00;
  end

endmodule

`default_nettype wire

FILE: sv/stx_etx_escape_deframer_ring.sv
// ---------------------------------------------------------------------------
// stx_etx_escape_deframer_ring
// STX/ETX/escape deframer feeding a receive ring with pop, peek and skip.
// ---------------------------------------------------------------------------
// Input channel (in_valid, in_stall, in_data): one transfer is a received
// byte, a pop, a peek at an offset from the oldest byte, or a skip that
// moves the read pointer and rearms the parser. Every transfer gives exactly
// one result on the output channel (out_valid, out_stall, out_data), in order.
// An input transfer is stored in the queue, then executed into the result
// register, from which its result is shown until it is taken.
// Throughput: one transfer per cycle, sustained while out_stall is low; the
// single execution unit owning the ring pointers and one memory port sets it.
// A two-entry queue sits between classifier and execution unit, and the
// result register is held while out_stall is high; in_stall rises only when
// the queue is full, so up to three items can be in flight during a stall.
// Reset (rst_n low, synchronous) empties the ring and the queue and returns
// the parser to awaiting start. Ring contents are not cleared: a peek of a
// never-written entry returns an unspecified byte.
// ---------------------------------------------------------------------------
`default_nettype none

module stx_etx_escape_deframer_ring
  import stxdef_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  item_t cls_item, head_item;
  logic  q_full, q_not_empty, q_pop;

  // classification
  stxdef_front #(
    .RING_DEPTH(RING_DEPTH)
  ) u_front (
    .in_data (in_data),
    .item    (cls_item)
  );

  assign in_stall = q_full;

  // decoupling queue
  stxdef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // execution
  stxdef_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/stxdef_checker.sv
// ---------------------------------------------------------------------------
// stxdef_checker
// Port-level checks on the result channel of the deframer.
// ---------------------------------------------------------------------------
`default_nettype none

module stxdef_checker
  import stxdef_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // ring cannot be both empty and full
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("empty and full together");

  // no read byte without a read
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |-> out_data.read_data == 8'h00)
    else $error("read data not zero");

  // a stored byte leaves the ring non-empty and the parser in frame
  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_stored |->
      !out_data.is_empty && out_data.frame_state == FS_FRAME && !out_data.read_valid)
    else $error("inconsistent store result");

endmodule

bind stx_etx_escape_deframer_ring stxdef_checker u_stxdef_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: dv/stx_etx_escape_deframer_ring_test.sv
// ---------------------------------------------------------------------------
// stx_etx_escape_deframer_ring_test
// Self-checking bench for the STX/ETX escape deframer and its receive ring.
// A short stimulus table covers the reset state, the parser transitions,
// escaped control bytes, ring overwrite, pop on an empty ring and skip with
// rearm. Random frames with escapes, pops, peeks and line noise follow. Each
// result is checked field by field against a local model of the parser and
// ring, with random gaps on the input side and random stalls on the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stx_etx_escape_deframer_ring_test;
  import stxdef_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int ITEM_TARGET = 1150;

  // one row of the stimulus table
  typedef struct {
    in_t  item;
    int   reps;
    bit   typed;
    out_t want;
  } drow_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // model of the ring and parser
  logic [7:0] ring_bytes [DEPTH];
  bit         ring_written [DEPTH];
  bit         any_written = 1'b0;
  int         wr_ptr = 0;
  int         rd_ptr = 0;
  bit         ring_full = 1'b0;
  logic [1:0] parse = FS_AWAIT;

  out_t pending_results [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   useful_items = 0;
  bit   send_quiet = 1'b0;
  bit   stall_quiet = 1'b0;
  int   stall_left = 0;
  drow_t dir_rows [$];

  stx_etx_escape_deframer_ring i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // ring write with overwrite of the oldest byte when full
  task automatic ring_store(logic [7:0] b);
    ring_bytes[wr_ptr] = b;
    ring_written[wr_ptr] = 1'b1;
    any_written = 1'b1;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (ring_full) rd_ptr = (rd_ptr + 1) % DEPTH;
    ring_full = (wr_ptr == rd_ptr);
  endtask

  // advance the model by one transfer and work out its result
  task automatic deframe_step(input in_t it, output out_t res, output bit acted);
    logic [1:0] old_parse;
    bit         empty_now;
    old_parse = parse;
    res = '0;
    case (op_t'(it.kind))
      OP_RX: begin
        if (parse == FS_AWAIT) begin
          if (it.rx_byte == CH_STX) parse = FS_FRAME;
          else if (it.rx_byte == CH_ESC) parse = FS_ESC;
          else if (it.rx_byte == CH_ETX) parse = FS_DONE;
        end else if (parse == FS_FRAME) begin
          if (it.rx_byte == CH_ESC) parse = FS_ESC;
          else if (it.rx_byte == CH_ETX) parse = FS_DONE;
          else begin
            ring_store(it.rx_byte);
            res.byte_stored = 1'b1;
          end
        end else if (parse == FS_ESC) begin
          ring_store(it.rx_byte);
          res.byte_stored = 1'b1;
          parse = FS_FRAME;
        end
      end
      OP_POP: begin
        if (ring_full || wr_ptr != rd_ptr) begin
          res.read_data = ring_bytes[rd_ptr];
          res.read_valid = 1'b1;
          ring_full = 1'b0;
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
      OP_PEEK: begin
        res.read_data = ring_bytes[(rd_ptr + int'(it.offset)) % DEPTH];
        res.read_valid = 1'b1;
      end
      default: begin
        rd_ptr = (rd_ptr + int'(it.offset)) % DEPTH;
        ring_full = 1'b0;
        parse = FS_AWAIT;
      end
    endcase
    empty_now = !ring_full && wr_ptr == rd_ptr;
    res.is_empty = empty_now;
    res.is_full = ring_full;
    res.frame_state = parse;
    acted = !(op_t'(it.kind) == OP_RX && !res.byte_stored && parse == old_parse);
  endtask

  function automatic int pick_gap();
    int unsigned r;
    if (send_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one transfer, wait for it to be taken, then queue its result
  task automatic send_item(in_t it, bit typed = 1'b0, out_t want = '0);
    int   gap;
    out_t predicted;
    bit   acted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(it, predicted, acted);
    if (acted) useful_items++;
    pending_results.push_back(typed ? want : predicted);
  endtask

  function automatic in_t mk_item(op_t k, logic [7:0] b, logic [7:0] off);
    in_t it;
    it.kind = k;
    it.rx_byte = b;
    it.offset = off;
    return it;
  endfunction

  // offset landing on an entry that has been written
  function automatic logic [7:0] peek_offset();
    int idx;
    int base;
    idx = $urandom_range(0, DEPTH - 1);
    while (!ring_written[idx]) idx = (idx + 1) % DEPTH;
    base = (idx - rd_ptr + DEPTH) % DEPTH;
    return 8'(base + DEPTH * $urandom_range(0, (255 - base) / DEPTH));
  endfunction

  function automatic in_t rnd_read();
    if (any_written && $urandom_range(0, 4) == 0)
      return mk_item(OP_PEEK, 8'($urandom), peek_offset());
    return mk_item(OP_POP, 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 11))
      0:       return CH_STX;
      1:       return CH_ETX;
      2:       return CH_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic out_t res(logic [7:0] d, logic v, logic s, logic e, logic f,
                               logic [1:0] st);
    out_t r;
    r.read_data = d;
    r.read_valid = v;
    r.byte_stored = s;
    r.is_empty = e;
    r.is_full = f;
    r.frame_state = st;
    return r;
  endfunction

  function automatic drow_t mk_row(op_t k, logic [7:0] b, logic [7:0] off, int reps = 1,
                                   bit typed = 1'b0, out_t want = '0);
    drow_t r;
    r.item = mk_item(k, b, off);
    r.reps = reps;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // frame with random payload, mostly closed by ETX, then some reads
  task automatic frame_episode();
    int         len;
    logic [7:0] b;
    if (parse == FS_DONE || $urandom_range(0, 5) == 0)
      send_item(mk_item(OP_SKIP, 8'($urandom),
                        $urandom_range(0, 1) ? 8'd0 : 8'($urandom)));
    // line noise before the start byte
    repeat ($urandom_range(0, 2))
      send_item(mk_item(OP_RX, 8'($urandom_range(8'h20, 8'hFF)), 8'($urandom)));
    send_item(mk_item(OP_RX, CH_STX, 8'($urandom)));
    len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 24) : $urandom_range(50, 90);
    repeat (len) begin
      b = rnd_byte();
      if (b == CH_ETX || b == CH_ESC || $urandom_range(0, 9) == 0)
        send_item(mk_item(OP_RX, CH_ESC, 8'($urandom)));
      send_item(mk_item(OP_RX, b, 8'($urandom)));
      if ($urandom_range(0, 7) == 0) send_item(rnd_read());
    end
    if ($urandom_range(0, 9) != 0) send_item(mk_item(OP_RX, CH_ETX, 8'($urandom)));
    repeat ($urandom_range(0, len + 2)) send_item(rnd_read());
  endtask

  // any kind, any content
  task automatic noise_episode();
    in_t it;
    repeat ($urandom_range(5, 20)) begin
      it = mk_item(op_t'($urandom_range(0, 3)), rnd_byte(), 8'($urandom));
      if (op_t'(it.kind) == OP_PEEK) begin
        if (any_written) it.offset = peek_offset();
        else it.kind = OP_POP;
      end
      send_item(it);
    end
  endtask

  task automatic flag_mismatch(string field, int got, int want);
    $display("tb: mismatch in %s of result %0d: got 0x%0h, want 0x%0h",
             field, results_seen, got, want);
    mismatches++;
  endtask

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data != want.read_data)
          flag_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.read_valid != want.read_valid)
          flag_mismatch("read_valid", out_data.read_valid, want.read_valid);
        if (out_data.byte_stored != want.byte_stored)
          flag_mismatch("byte_stored", out_data.byte_stored, want.byte_stored);
        if (out_data.is_empty != want.is_empty)
          flag_mismatch("is_empty", out_data.is_empty, want.is_empty);
        if (out_data.is_full != want.is_full)
          flag_mismatch("is_full", out_data.is_full, want.is_full);
        if (out_data.frame_state != want.frame_state)
          flag_mismatch("frame_state", out_data.frame_state, want.frame_state);
      end
      results_seen++;
    end
    if ($urandom_range(0, 199) == 0) stall_quiet = !stall_quiet;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_quiet) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0:       stall_left = $urandom_range(8, 30);
        1, 2, 3,
        4, 5:    stall_left = $urandom_range(1, 3);
        default: stall_left = 0;
      endcase
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // stimulus
  initial begin
    // after reset, parser moves in every state, escaped control bytes
    dir_rows.push_back(mk_row(OP_POP, 8'hA7, 8'h5C, 1, 1, res(0, 0, 0, 1, 0, FS_AWAIT)));
    dir_rows.push_back(mk_row(OP_RX, 8'h55, 8'hFF, 1, 1, res(0, 0, 0, 1, 0, FS_AWAIT)));
    dir_rows.push_back(mk_row(OP_RX, CH_ETX, 8'h00, 1, 1, res(0, 0, 0, 1, 0, FS_DONE)));
    dir_rows.push_back(mk_row(OP_RX, 8'h41, 8'h12, 1, 1, res(0, 0, 0, 1, 0, FS_DONE)));
    dir_rows.push_back(mk_row(OP_RX, CH_STX, 8'h00, 1, 1, res(0, 0, 0, 1, 0, FS_DONE)));
    dir_rows.push_back(mk_row(OP_SKIP, 8'hFF, 8'h00, 1, 1, res(0, 0, 0, 1, 0, FS_AWAIT)));
    dir_rows.push_back(mk_row(OP_RX, CH_ESC, 8'h00, 1, 1, res(0, 0, 0, 1, 0, FS_ESC)));
    dir_rows.push_back(mk_row(OP_RX, CH_ETX, 8'h00, 1, 1, res(0, 0, 1, 0, 0, FS_FRAME)));
    dir_rows.push_back(mk_row(OP_RX, CH_STX, 8'h00));
    dir_rows.push_back(mk_row(OP_RX, 8'hFF, 8'h00));
    dir_rows.push_back(mk_row(OP_RX, 8'h00, 8'hFF));
    dir_rows.push_back(mk_row(OP_RX, CH_ESC, 8'h00));
    dir_rows.push_back(mk_row(OP_RX, CH_ESC, 8'h00));
    dir_rows.push_back(mk_row(OP_PEEK, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_PEEK, 8'hFF, 8'h44));
    dir_rows.push_back(mk_row(OP_POP, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_RX, CH_ETX, 8'h00));
    // skip past the write pointer, wrapping the read pointer
    dir_rows.push_back(mk_row(OP_SKIP, 8'h00, 8'hFF));
    // overfill the ring so the oldest bytes are overwritten
    dir_rows.push_back(mk_row(OP_RX, CH_STX, 8'h00));
    dir_rows.push_back(mk_row(OP_RX, 8'hA5, 8'h00, 70));
    dir_rows.push_back(mk_row(OP_PEEK, 8'h00, 8'hFF));
    dir_rows.push_back(mk_row(OP_POP, 8'h00, 8'h00));
    // skip that lands on the write pointer leaves the ring empty
    dir_rows.push_back(mk_row(OP_SKIP, 8'h00, 8'hBF));
    dir_rows.push_back(mk_row(OP_POP, 8'h5A, 8'hC3, 1, 1, res(0, 0, 0, 1, 0, FS_AWAIT)));
    dir_rows.push_back(mk_row(OP_PEEK, 8'h00, 8'h80));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      repeat (dir_rows[i].reps) send_item(dir_rows[i].item, dir_rows[i].typed,
                                          dir_rows[i].want);

    // random frames and noise
    while (useful_items < ITEM_TARGET) begin
      send_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) frame_episode();
      else noise_episode();
    end
    in_valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
sv/stxdef_pkg.sv
sv/stxdef_front.sv
sv/stxdef_queue.sv
sv/stxdef_back.sv
sv/stx_etx_escape_deframer_ring.sv
sv/stxdef_checker.sv
dv/stx_etx_escape_deframer_ring_test.sv
